@@ rtl/adler32_length_prefixed_deframer_assert.svh @@
// assertion macros shared by the deframer rtl
// no dependencies; compiled to empty bodies when SYNTHESIS is defined
`ifndef ADLER32_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define ADLER32_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// property holds at every edge out of reset
`define A32D_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define A32D_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define A32D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define A32D_ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define A32D_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define A32D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/a32d_pkg.sv @@
// types and constants of the length-prefixed adler-32 deframer
// no dependencies
package a32d_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned CFG_W        = 31;

  localparam logic [CFG_W-1:0] MIN_FRAME_LEN_RST = 31'd10;
  localparam logic [CFG_W-1:0] MAX_FRAME_LEN_RST = 31'd67108864;

  localparam logic CFG_IDX_MIN_LEN = 1'b0;
  localparam logic CFG_IDX_MAX_LEN = 1'b1;

  localparam logic [16:0] ADLER_MOD   = 17'd65521;
  localparam logic [15:0] SUM_LOW_RST = 16'd1;

  localparam logic [31:0] HDR_LEN      = 32'(HEADER_BYTES);
  localparam logic [31:0] MIN_BODY_LEN = 32'(2 * HEADER_BYTES);
  localparam logic [31:0] MIN_NAME_LEN = 32'd2;
  localparam logic [30:0] HDR_LAST_IDX = 31'(HEADER_BYTES - 1);

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_LEN      = 3'd0,
    ROLE_NAME_LEN = 3'd1,
    ROLE_NAME     = 3'd2,
    ROLE_PAYLOAD  = 3'd3,
    ROLE_CHECK    = 3'd4
  } role_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_BAD_NAME = 2'd3
  } status_t;

  typedef struct packed {
    logic       init;
    logic       update;
    logic [7:0] data;
  } adler_ctl_t;

endpackage

@@ rtl/a32d_cfg_regs.sv @@
// frame length limit registers
// depends on a32d_pkg
module a32d_cfg_regs
  import a32d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic             index,
  input  logic [CFG_W-1:0] data,
  output logic [CFG_W-1:0] min_len,
  output logic [CFG_W-1:0] max_len
);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_FRAME_LEN_RST;
      max_len <= MAX_FRAME_LEN_RST;
    end else if (we) begin
      if (index == CFG_IDX_MIN_LEN) begin
        min_len <= data;
      end else begin
        max_len <= data;
      end
    end
  end

endmodule

@@ rtl/a32d_adler_acc.sv @@
// adler-32 running sums, one byte per cycle with conditional modulo subtract
// depends on a32d_pkg and the assertion macro header
`include "adler32_length_prefixed_deframer_assert.svh"
module a32d_adler_acc
  import a32d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  adler_ctl_t  ctl,
  output logic [31:0] sum
);

  logic [15:0] sum_low;
  logic [15:0] sum_high;
  logic [16:0] low_add;
  logic [16:0] low_mod;
  logic [16:0] high_add;
  logic [16:0] high_mod;

  always_comb begin
    low_add  = {1'b0, sum_low} + {9'b0, ctl.data};
    low_mod  = (low_add >= ADLER_MOD) ? (low_add - ADLER_MOD) : low_add;
    high_add = {1'b0, sum_high} + {1'b0, low_mod[15:0]};
    high_mod = (high_add >= ADLER_MOD) ? (high_add - ADLER_MOD) : high_add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_low  <= SUM_LOW_RST;
      sum_high <= '0;
    end else if (ctl.init) begin
      sum_low  <= SUM_LOW_RST;
      sum_high <= '0;
    end else if (ctl.update) begin
      sum_low  <= low_mod[15:0];
      sum_high <= high_mod[15:0];
    end
  end

  assign sum = {sum_high, sum_low};

  `A32D_ASSERT_ALWAYS(a_low_reduced, clk, rst, ({1'b0, sum_low} < ADLER_MOD), "sum_low not reduced")
  `A32D_ASSERT_ALWAYS(a_high_reduced, clk, rst, ({1'b0, sum_high} < ADLER_MOD), "sum_high not reduced")

endmodule

@@ rtl/a32d_frame_ctl.sv @@
// frame parser: phase, counters, length fields, status and result register
// depends on a32d_pkg and the assertion macro header
`include "adler32_length_prefixed_deframer_assert.svh"
module a32d_frame_ctl
  import a32d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             out_take,
  input  logic [7:0]       data_in,
  input  logic             restart_in,
  input  logic [CFG_W-1:0] min_len,
  input  logic [CFG_W-1:0] max_len,
  input  logic [31:0]      adler_sum,
  output adler_ctl_t       adler_ctl,
  output logic             res_valid,
  output logic [7:0]       res_byte,
  output logic [2:0]       res_role,
  output logic             res_end,
  output logic [1:0]       res_status
);

  phase_t      phase, phase_next;
  logic [30:0] byte_count, byte_count_next;
  logic [31:0] frame_length, frame_length_next;
  logic [31:0] name_length, name_length_next;
  logic [31:0] received_check, received_check_next;
  logic        halted, halted_next;

  // state as seen by this item, after a restart has cleared it
  phase_t      eff_phase;
  logic [30:0] eff_count;
  logic [31:0] eff_flen;
  logic [31:0] eff_nlen;
  logic [31:0] eff_rcheck;
  logic        eff_halted;
  logic        emit;

  logic [31:0] flen_shift;
  logic [31:0] nlen_shift;
  logic [31:0] rcheck_shift;
  logic [30:0] count_inc;
  logic        hdr_done;
  logic        bad_len;
  logic [31:0] i_ext;
  logic        in_check;
  logic        is_last;
  logic        in_nlen_field;
  logic        name_ok;
  logic        in_name;
  logic        sum_match;

  role_t       role_c;
  logic        end_c;
  status_t     status_c;

  assign eff_phase  = restart_in ? PH_HEADER : phase;
  assign eff_count  = restart_in ? '0 : byte_count;
  assign eff_flen   = restart_in ? '0 : frame_length;
  assign eff_nlen   = restart_in ? '0 : name_length;
  assign eff_rcheck = restart_in ? '0 : received_check;
  assign eff_halted = restart_in ? 1'b0 : halted;
  assign emit       = step && !eff_halted;

  assign flen_shift   = {eff_flen[23:0], data_in};
  assign nlen_shift   = {eff_nlen[23:0], data_in};
  assign rcheck_shift = {eff_rcheck[23:0], data_in};
  assign count_inc    = eff_count + 31'd1;
  assign hdr_done     = (eff_count == HDR_LAST_IDX);
  assign bad_len      = flen_shift[31] ||
                        (flen_shift[30:0] < min_len) ||
                        (flen_shift[30:0] > max_len) ||
                        (flen_shift < MIN_BODY_LEN);

  assign i_ext         = {1'b0, eff_count};
  assign in_check      = (i_ext >= (eff_flen - HDR_LEN));
  assign is_last       = ((i_ext + 32'd1) >= eff_flen);
  assign in_nlen_field = (i_ext < HDR_LEN);
  assign name_ok       = !eff_nlen[31] && (eff_nlen >= MIN_NAME_LEN) &&
                         (eff_nlen <= (eff_flen - MIN_BODY_LEN));
  assign in_name       = name_ok && ((i_ext - HDR_LEN) < eff_nlen);
  assign sum_match     = (adler_sum == rcheck_shift);

  // result fields of this item
  always_comb begin
    role_c   = ROLE_LEN;
    end_c    = 1'b0;
    status_c = ST_OK;
    unique case (eff_phase)
      PH_HEADER: begin
        if (hdr_done && bad_len) begin
          end_c    = 1'b1;
          status_c = ST_BAD_LEN;
        end
      end
      PH_BODY: begin
        if (in_check) begin
          role_c = ROLE_CHECK;
          if (is_last) begin
            end_c = 1'b1;
            if (!sum_match) begin
              status_c = ST_CHECKSUM;
            end else if (!name_ok) begin
              status_c = ST_BAD_NAME;
            end
          end
        end else if (in_nlen_field) begin
          role_c = ROLE_NAME_LEN;
        end else if (in_name) begin
          role_c = ROLE_NAME;
        end else begin
          role_c = ROLE_PAYLOAD;
        end
      end
      default: begin
        role_c = ROLE_LEN;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    frame_length_next   = frame_length;
    name_length_next    = name_length;
    received_check_next = received_check;
    halted_next         = halted;
    if (emit) begin
      phase_next          = eff_phase;
      byte_count_next     = eff_count;
      frame_length_next   = eff_flen;
      name_length_next    = eff_nlen;
      received_check_next = eff_rcheck;
      halted_next         = eff_halted;
      if (end_c) begin
        phase_next          = PH_HEADER;
        byte_count_next     = '0;
        frame_length_next   = '0;
        name_length_next    = '0;
        received_check_next = '0;
        halted_next         = (status_c != ST_OK);
      end else begin
        unique case (eff_phase)
          PH_HEADER: begin
            frame_length_next = flen_shift;
            if (hdr_done) begin
              phase_next      = PH_BODY;
              byte_count_next = '0;
            end else begin
              byte_count_next = count_inc;
            end
          end
          PH_BODY: begin
            byte_count_next = count_inc;
            if (in_check) begin
              received_check_next = rcheck_shift;
            end else if (in_nlen_field) begin
              name_length_next = nlen_shift;
            end
          end
          default: begin
            phase_next = PH_HEADER;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_count     <= '0;
      frame_length   <= '0;
      name_length    <= '0;
      received_check <= '0;
      halted         <= 1'b0;
    end else begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      frame_length   <= frame_length_next;
      name_length    <= name_length_next;
      received_check <= received_check_next;
      halted         <= halted_next;
    end
  end

  always_comb begin
    adler_ctl.init   = emit && (restart_in || end_c);
    adler_ctl.update = emit && (eff_phase == PH_BODY) && !in_check;
    adler_ctl.data   = data_in;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= !eff_halted;
    end else if (out_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_byte   <= data_in;
      res_role   <= role_c;
      res_end    <= end_c;
      res_status <= status_c;
    end
  end

  `A32D_ASSERT_NEXT(a_error_halts, clk, rst, emit && end_c && (status_c != ST_OK), halted, "frame error did not halt")
  `A32D_ASSERT_SAME(a_len_end_status, clk, rst, emit && end_c && (role_c == ROLE_LEN), status_c == ST_BAD_LEN, "header end without bad length")

endmodule

@@ rtl/adler32_length_prefixed_deframer.sv @@
// length-prefixed frame deframer with adler-32 check, one byte per item
// an accepted byte is held in the input register, its result item in the result register
// throughput: 1 item per cycle while out_stall is low, bounded by the adler-32 update
// reset: synchronous, active high; limits return to 10 and 67108864, block unhalted
// depends on a32d_pkg, a32d_cfg_regs, a32d_adler_acc, a32d_frame_ctl and the assertion macro header
`include "adler32_length_prefixed_deframer_assert.svh"
module adler32_length_prefixed_deframer
  import a32d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration write port
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // input item channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  input  logic             restart,
  // result item channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic [2:0]       role,
  output logic             frame_end,
  output logic [1:0]       status
);

  logic [CFG_W-1:0] min_len;
  logic [CFG_W-1:0] max_len;
  logic [31:0]      adler_sum;
  adler_ctl_t       adler_ctl;

  // input register holds one item between the channel and the parser
  logic       in_full;
  logic [7:0] in_byte_r;
  logic       in_restart_r;
  logic       in_take;
  logic       out_take;
  logic       load;

  // the parser moves an item whenever the result register is free or drains now
  assign out_take = out_valid && !out_stall;
  assign load     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r    <= rx_byte;
      in_restart_r <= restart;
    end
  end

  a32d_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .we      (cfg_we),
    .index   (cfg_index),
    .data    (cfg_data),
    .min_len (min_len),
    .max_len (max_len)
  );

  // running checksum over body bytes ahead of the trailing check field
  a32d_adler_acc u_adler (
    .clk (clk),
    .rst (rst),
    .ctl (adler_ctl),
    .sum (adler_sum)
  );

  // halted items are consumed here without producing a result
  a32d_frame_ctl u_frame (
    .clk        (clk),
    .rst        (rst),
    .step       (load),
    .out_take   (out_take),
    .data_in    (in_byte_r),
    .restart_in (in_restart_r),
    .min_len    (min_len),
    .max_len    (max_len),
    .adler_sum  (adler_sum),
    .adler_ctl  (adler_ctl),
    .res_valid  (out_valid),
    .res_byte   (out_byte),
    .res_role   (role),
    .res_end    (frame_end),
    .res_status (status)
  );

  `A32D_ASSERT_NEXT(a_in_held, clk, rst, in_full && !load, in_full, "buffered item lost while stalled")

endmodule

@@ bench/tb.sv @@
// self-checking bench for the length-prefixed adler-32 deframer
// depends on a32d_pkg and the adler32_length_prefixed_deframer rtl
// directed rows first, then random frames under several limit settings
module tb;
  import a32d_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  // quiet time after the last owed item is taken, before config is touched
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_t;

  // one tagged output item as the block should present it
  typedef struct packed {
    logic [7:0] data;
    role_t      role;
    logic       fend;
    status_t    st;
  } tag_t;

  // one input item
  typedef struct packed {
    logic [7:0] b;
    logic       r;
  } rx_item_t;

  // directed row: fixed=1 means the expectation is typed in below
  typedef struct packed {
    logic [7:0] b;
    logic       r;
    bit         fixed;
    bit         want;
    tag_t       tag;
  } dir_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    int               target;
  } limit_set_t;

  // clock, reset and block inputs, all known from time zero
  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = CFG_IDX_MIN_LEN;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic [7:0]       rx_byte   = 8'd0;
  logic             restart   = 1'b0;
  logic             out_stall = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [2:0] role;
  logic       frame_end;
  logic [1:0] status;

  adler32_length_prefixed_deframer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .role      (role),
    .frame_end (frame_end),
    .status    (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // deframer shadow state, updated once per accepted item
  logic [CFG_W-1:0] min_len;
  logic [CFG_W-1:0] max_len;
  phase_t           phase;
  logic [31:0]      byte_cnt;
  logic [31:0]      frm_len;
  logic [31:0]      nm_len;
  logic [15:0]      sum_lo;
  logic [15:0]      sum_hi;
  logic [31:0]      rx_chk;
  bit               halted;

  tag_t     role_tags_q[$];   // tagged items still owed by the block
  rx_item_t stim_q[$];        // bytes of the frame being sent
  idle_t    idle_mode = IDLE_NONE;
  int       n_results = 0;
  int       n_errors  = 0;
  int       cycles    = 0;

  dir_row_t   dir_rows[25];
  limit_set_t limit_sets[6];

  function automatic void clear_frame();
    phase    = PH_HEADER;
    byte_cnt = '0;
    frm_len  = '0;
    nm_len   = '0;
    sum_lo   = SUM_LOW_RST;
    sum_hi   = '0;
    rx_chk   = '0;
  endfunction

  // name length must leave room for itself and the checksum
  function automatic bit name_len_ok();
    logic [31:0] room;
    room = frm_len - MIN_BODY_LEN;
    return !nm_len[31] && nm_len >= MIN_NAME_LEN && nm_len <= room;
  endfunction

  // tags one byte; got=0 when the block is halted and drops it
  task automatic deframe_predict(input logic [7:0] b, input logic r,
                                 output bit got, output tag_t t);
    logic [31:0] i;
    logic [31:0] calc;
    logic [16:0] acc;
    got = 1'b0;
    t   = '{b, ROLE_LEN, 1'b0, ST_OK};
    if (r) begin
      halted = 1'b0;
      clear_frame();
    end
    if (halted) return;
    got = 1'b1;
    n_results++;
    if (phase == PH_HEADER) begin
      frm_len  = {frm_len[23:0], b};
      byte_cnt = byte_cnt + 32'd1;
      if (byte_cnt >= HDR_LEN) begin
        // negative, out of limits, or too short for name length plus checksum
        if (frm_len[31] || frm_len < {1'b0, min_len} || frm_len > {1'b0, max_len} ||
            frm_len < MIN_BODY_LEN) begin
          t.fend = 1'b1;
          t.st   = ST_BAD_LEN;
          halted = 1'b1;
          clear_frame();
        end else begin
          phase    = PH_BODY;
          byte_cnt = '0;
        end
      end
    end else begin
      i = byte_cnt;
      if (i >= frm_len - HDR_LEN) begin
        t.role = ROLE_CHECK;
        rx_chk = {rx_chk[23:0], b};
        if (i + 32'd1 >= frm_len) begin
          calc   = {sum_hi, sum_lo};
          t.fend = 1'b1;
          // checksum error wins over a bad name length
          if (calc != rx_chk) t.st = ST_CHECKSUM;
          else if (!name_len_ok()) t.st = ST_BAD_NAME;
          if (t.st != ST_OK) halted = 1'b1;
          clear_frame();
        end
      end else begin
        acc = {1'b0, sum_lo} + b;
        if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
        sum_lo = acc[15:0];
        acc = {1'b0, sum_hi} + sum_lo;
        if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
        sum_hi = acc[15:0];
        if (i < HDR_LEN) begin
          t.role = ROLE_NAME_LEN;
          nm_len = {nm_len[23:0], b};
        end else if (name_len_ok() && i - HDR_LEN < nm_len) begin
          t.role = ROLE_NAME;
        end else begin
          t.role = ROLE_PAYLOAD;
        end
      end
      if (!t.fend) byte_cnt = i + 32'd1;
    end
  endtask

  function automatic int idle_pct(bit rx_side);
    case (idle_mode)
      IDLE_SEND: return rx_side ? 0 : 67;
      IDLE_RECV: return rx_side ? 67 : 0;
      IDLE_BOTH: return 31;
      default:   return 0;
    endcase
  endfunction

  // entered just after a falling edge, returns just after a falling edge
  task automatic send_item(input rx_item_t it, input bit fixed, input bit fixed_want,
                           input tag_t fixed_tag);
    bit   got;
    tag_t t;
    while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= it.b;
    restart  <= it.r;
    do @(posedge clk); while (in_stall);
    deframe_predict(it.b, it.r, got, t);
    if (fixed) begin
      got = fixed_want;
      t   = fixed_tag;
    end
    if (got) role_tags_q.push_back(t);
    @(negedge clk);
  endtask

  // sender quiet, all owed items in, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (role_tags_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one random frame, mostly well formed, sometimes broken on purpose
  task automatic build_frame();
    logic [31:0] flen;
    logic [31:0] nlen;
    logic [31:0] chk;
    logic [7:0]  bt;
    int          pick;
    int          a;
    int          s;
    // stray bytes between frames: dropped when halted, misalign otherwise
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) stim_q.push_back('{8'($urandom_range(0, 255)), 1'b0});
    pick = $urandom_range(0, 99);
    if (pick < 70) flen = $urandom_range(8, 48);
    else if (pick < 80) flen = $urandom_range(0, 7);
    else if (pick < 90) flen = $urandom();
    else begin
      // limit boundaries, wrapping into negative lengths at the extremes
      case ($urandom_range(0, 3))
        0:       flen = {1'b0, min_len} - 32'd1;
        1:       flen = {1'b0, min_len};
        2:       flen = {1'b0, max_len};
        default: flen = {1'b0, max_len} + 32'd1;
      endcase
    end
    // restart on the first header byte most of the time
    stim_q.push_back('{flen[31:24], 1'($urandom_range(0, 99) < 85)});
    stim_q.push_back('{flen[23:16], 1'b0});
    stim_q.push_back('{flen[15:8], 1'b0});
    stim_q.push_back('{flen[7:0], 1'b0});
    if (flen >= MIN_BODY_LEN && flen <= 32'd64) begin
      if (flen >= 32'd10 && $urandom_range(0, 99) < 75) begin
        nlen = $urandom_range(2, int'(flen) - 8);
      end else begin
        case ($urandom_range(0, 4))
          0:       nlen = 32'd0;
          1:       nlen = 32'd1;
          2:       nlen = flen - 32'd7;
          3:       nlen = $urandom() | 32'h8000_0000;
          default: nlen = $urandom();
        endcase
      end
      a = 1;
      s = 0;
      for (int k = 0; k < int'(flen) - 4; k++) begin
        if (k < 4) bt = nlen[31 - 8*k -: 8];
        else if (k - 4 == nlen - 32'd1) bt = 8'd0;   // name terminator
        else bt = $urandom_range(0, 255);
        a = (a + bt) % ADLER_MOD;
        s = (s + a) % ADLER_MOD;
        stim_q.push_back('{bt, 1'b0});
      end
      chk = {s[15:0], a[15:0]};
      if ($urandom_range(0, 99) < 15) chk = chk ^ (32'd1 << $urandom_range(0, 31));
      for (int k = 0; k < 4; k++) stim_q.push_back('{chk[31 - 8*k -: 8], 1'b0});
    end
    // cut the frame short now and then; the next restart drops the rest
    if ($urandom_range(0, 19) == 0)
      repeat ($urandom_range(1, 6)) if (stim_q.size() > 1) void'(stim_q.pop_back());
  endtask

  // receiver stalls at random, changing only on the falling edge
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < idle_pct(1'b1));
  end

  // every accepted output item is checked against the oldest owed item
  always @(posedge clk) begin
    tag_t e;
    if (!rst && out_valid && !out_stall) begin
      if (role_tags_q.size() == 0) begin
        n_errors++;
        $display("%0t unexpected item: byte %02h role %0d end %0b status %0d",
                 $time, out_byte, role, frame_end, status);
      end else begin
        e = role_tags_q.pop_front();
        if (out_byte !== e.data || role !== e.role || frame_end !== e.fend ||
            status !== e.st) begin
          n_errors++;
          $display("%0t mismatch: expected byte %02h role %0d end %0b status %0d",
                   $time, e.data, e.role, e.fend, e.st);
          $display("%0t           actual   byte %02h role %0d end %0b status %0d",
                   $time, out_byte, role, frame_end, status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int base;
    dir_rows = '{
      // negative length under reset limits, rejected on its last byte
      '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'hFF, ROLE_LEN, 1'b0, ST_OK}},
      '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'hFF, ROLE_LEN, 1'b0, ST_OK}},
      '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'hFF, ROLE_LEN, 1'b0, ST_OK}},
      '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'hFF, ROLE_LEN, 1'b1, ST_BAD_LEN}},
      // halted: dropped without output
      '{8'h00, 1'b0, 1'b1, 1'b0, '0},
      // restart into a minimum-size good frame: length 10, name "a\0"
      '{8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'hCE, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h64, 1'b0, 1'b0, 1'b0, '0},
      // half a header, then restart mid-header with a too-small length
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, ROLE_LEN, 1'b0, ST_OK}},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, ROLE_LEN, 1'b0, ST_OK}},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, ROLE_LEN, 1'b0, ST_OK}},
      '{8'h05, 1'b0, 1'b1, 1'b1, '{8'h05, ROLE_LEN, 1'b1, ST_BAD_LEN}}
    };
    // limit settings: reset values, widest, narrow, both at max, both zero, typical
    limit_sets = '{
      '{31'd10,          31'd67108864,    280},
      '{31'd0,           31'h7FFF_FFFF,   280},
      '{31'd12,          31'd30,          280},
      '{31'h7FFF_FFFF,   31'h7FFF_FFFF,   100},
      '{31'd0,           31'd0,           100},
      '{31'd8,           31'd64,          280}
    };

    min_len = MIN_FRAME_LEN_RST;
    max_len = MAX_FRAME_LEN_RST;
    halted  = 1'b0;
    clear_frame();

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k])
      send_item('{dir_rows[k].b, dir_rows[k].r}, dir_rows[k].fixed, dir_rows[k].want,
                dir_rows[k].tag);

    foreach (limit_sets[c]) begin
      settle();
      // both limit registers, written back to back while idle
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_MIN_LEN;
      cfg_data  <= limit_sets[c].lo;
      @(negedge clk);
      cfg_index <= CFG_IDX_MAX_LEN;
      cfg_data  <= limit_sets[c].hi;
      @(negedge clk);
      cfg_we  <= 1'b0;
      min_len = limit_sets[c].lo;
      max_len = limit_sets[c].hi;
      base    = n_results;
      while (n_results - base < limit_sets[c].target) begin
        // rotate idling style every few dozen output items
        idle_mode = idle_t'(((n_results - base) / 70) % 4);
        build_frame();
        while (stim_q.size() > 0) send_item(stim_q.pop_front(), 1'b0, 1'b0, '0);
      end
    end

    settle();
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
